@@ design/mcdc_pkg.sv @@
// Shared constants, types and codes of the masked column disagreement counter.
package mcdc_pkg;

	// Store geometry
	localparam int WORD_BITS  = 64;
	localparam int MAX_WORDS  = 16;
	localparam int COUNT_BITS = 32;
	localparam int ROW_BITS   = $clog2(MAX_WORDS);
	localparam int COL_BITS   = $clog2(WORD_BITS);
	localparam int ATTR_BITS  = ROW_BITS + COL_BITS;
	localparam int ROW_WIDTH  = WORD_BITS * COUNT_BITS;

	// Configuration
	localparam int ACNT_BITS  = 11;
	localparam int ADDR_BITS  = 3;
	localparam logic [ACNT_BITS-1:0] ACNT_RESET = ACNT_BITS'(1024);
	localparam logic REG_ATTR_COUNT = 1'b0;

	// Item commands
	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_SUB   = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} command_t;

	// Controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_t;

endpackage

@@ design/mcdc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mcdc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/mcdc_ctrl.sv @@
// Controller: accepts an item and sequences its read-modify-write cycle.
module mcdc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output mcdc_pkg::ctrl_t ctrl
);

	mcdc_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcdc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		busy      = 1'b0;
		ctrl.load = 1'b0;
		ctrl.exec = 1'b0;
		case (state_q)
			mcdc_pkg::ST_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = mcdc_pkg::ST_EXEC;
				end
			end
			mcdc_pkg::ST_EXEC: begin
				busy      = 1'b1;
				ctrl.exec = 1'b1;
				state_d   = mcdc_pkg::ST_IDLE;
			end
			default: begin
				state_d = mcdc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/mcdc_dpath.sv @@
// Datapath: row store, per-column saturating update and counter read-out.
module mcdc_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mcdc_pkg::ctrl_t                ctrl,
	input  logic [mcdc_pkg::ACNT_BITS-1:0] attribute_count,
	input  logic [1:0]                     command,
	input  logic [3:0]                     word_index,
	input  logic [63:0]                    word_a,
	input  logic [63:0]                    word_b,
	input  logic [63:0]                    skip_mask,
	input  logic                           line_skipped,
	input  logic [9:0]                     attribute_index,
	output logic                           result_valid,
	output logic [31:0]                    count_value,
	output logic [9:0]                     count_attribute
);

	localparam int WB = mcdc_pkg::WORD_BITS;
	localparam int CB = mcdc_pkg::COUNT_BITS;
	localparam int RB = mcdc_pkg::ROW_BITS;
	localparam int LB = mcdc_pkg::COL_BITS;

	// item registers
	mcdc_pkg::command_t cmd_s1;
	logic [RB-1:0]      row_s1;
	logic [WB-1:0]      diff_s1;
	logic               skip_s1;
	logic [9:0]         attr_s1;

	logic [mcdc_pkg::MAX_WORDS-1:0] valid_q;
	logic                           result_valid_q;
	logic [31:0]                    count_value_q;
	logic [9:0]                     count_attr_q;

	logic [RB-1:0]                  raddr;
	logic [mcdc_pkg::ROW_WIDTH-1:0] rdata;
	logic [mcdc_pkg::ROW_WIDTH-1:0] row_data;
	logic [mcdc_pkg::ROW_WIDTH-1:0] new_row;
	logic [mcdc_pkg::ROW_WIDTH-1:0] wdata;
	logic                           we;
	logic [CB-1:0]                  sel_count;

	// read address taken straight from the ports so data is ready in the next cycle
	assign raddr = (mcdc_pkg::command_t'(command) == mcdc_pkg::CMD_READ)
		? attribute_index[9 -: RB] : word_index[RB-1:0];

	mcdc_ram #(
		.WIDTH (mcdc_pkg::ROW_WIDTH),
		.DEPTH (mcdc_pkg::MAX_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (row_s1),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// capture the item on acceptance
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_s1  <= mcdc_pkg::command_t'(command);
			row_s1  <= raddr;
			diff_s1 <= (word_a[WB-1:0] ^ word_b[WB-1:0]) & ~skip_mask[WB-1:0];
			skip_s1 <= line_skipped;
			attr_s1 <= attribute_index;
		end
	end

	// rows never written since reset read as zero
	assign row_data = valid_q[row_s1] ? rdata : '0;

	// per-column saturating increment or decrement
	always_comb begin
		logic [CB-1:0]        cnt;
		logic                 en;
		logic [RB+LB:0]       col;
		for (int k = 0; k < WB; k++) begin
			cnt = row_data[k*CB +: CB];
			col = {1'b0, row_s1, LB'(k)};
			en  = diff_s1[WB-1-k] && (col < (RB+LB+1)'(attribute_count));
			if (en && cmd_s1 == mcdc_pkg::CMD_ADD && cnt != '1) begin
				cnt = cnt + CB'(1);
			end else if (en && cmd_s1 == mcdc_pkg::CMD_SUB && cnt != '0) begin
				cnt = cnt - CB'(1);
			end
			new_row[k*CB +: CB] = cnt;
		end
	end

	// write-back of the updated or cleared row
	always_comb begin
		we    = 1'b0;
		wdata = new_row;
		case (cmd_s1)
			mcdc_pkg::CMD_ADD,
			mcdc_pkg::CMD_SUB: we = ctrl.exec && !skip_s1;
			mcdc_pkg::CMD_CLEAR: begin
				we    = ctrl.exec;
				wdata = '0;
			end
			default: we = 1'b0;
		endcase
	end

	assign sel_count = row_data[attr_s1[LB-1:0]*CB +: CB];

	// row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[row_s1] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= ctrl.exec && cmd_s1 == mcdc_pkg::CMD_READ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			count_value_q <= sel_count;
			count_attr_q  <= attr_s1;
		end
	end

	assign result_valid    = result_valid_q;
	assign count_value     = count_value_q;
	assign count_attribute = count_attr_q;

endmodule

@@ design/masked_column_disagreement_counter.sv @@
// Top level: configuration register, controller and datapath.
// Usage:
//   Command channel: an item is taken at a rising edge with start high and
//   busy low. command selects add, subtract, read or clear; word_index picks
//   the 64-column row; word_a, word_b and skip_mask give the disagreement
//   bits; attribute_index names the counter a read returns.
//   Result channel: a read gives count_value and count_attribute for exactly
//   one cycle with result_valid high, from the result register that is loaded in the execute state.
//   The receiver cannot stall; other commands give no result.
//   Items: no new item is taken while busy. The whole row of 64 counters is read
//   from the row store in the accept cycle and written back the next, so busy
//   stays high in the execute state, which does the write-back.
//   Configuration: APB register attribute_count at address 0; the user must see that it is
//   written only while idle, as the block does not enforce this; pready is always high.
//   Reset: counters read as zero (per-row valid bits cleared), attribute_count
//   returns to 1024, and the block is idle with busy low once reset is released.
module masked_column_disagreement_counter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mcdc_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     command,
	input  logic [3:0]                     word_index,
	input  logic [63:0]                    word_a,
	input  logic [63:0]                    word_b,
	input  logic [63:0]                    skip_mask,
	input  logic                           line_skipped,
	input  logic [9:0]                     attribute_index,
	output logic                           result_valid,
	output logic [31:0]                    count_value,
	output logic [9:0]                     count_attribute
);

	logic [mcdc_pkg::ACNT_BITS-1:0] attr_count_q;
	logic                           reg_sel;
	mcdc_pkg::ctrl_t                ctrl;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == mcdc_pkg::REG_ATTR_COUNT);

	// attribute count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_count_q <= mcdc_pkg::ACNT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			attr_count_q <= pwdata[mcdc_pkg::ACNT_BITS-1:0];
		end
	end

	assign prdata = reg_sel ? {{(32-mcdc_pkg::ACNT_BITS){1'b0}}, attr_count_q} : '0;

	mcdc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	mcdc_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.attribute_count (attr_count_q),
		.command         (command),
		.word_index      (word_index),
		.word_a          (word_a),
		.word_b          (word_b),
		.skip_mask       (skip_mask),
		.line_skipped    (line_skipped),
		.attribute_index (attribute_index),
		.result_valid    (result_valid),
		.count_value     (count_value),
		.count_attribute (count_attribute)
	);

endmodule
